// ===== src/blocked_prefix_sum_mod_prime_macros.svh =====
// assertion macros for the rtl files, included by the datapath
`ifndef BLOCKED_PREFIX_SUM_MOD_PRIME_MACROS_SVH
`define BLOCKED_PREFIX_SUM_MOD_PRIME_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BPSMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define BPSMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpsmp_pkg.sv =====
`default_nettype none

package bpsmp_pkg;

  localparam int unsigned IDX_W = 13;
  localparam int unsigned VAL_W = 30;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned MAX_ELEMENTS_DEF = 4096;
  localparam int unsigned BLOCK_SIZE_DEF = 64;

  localparam logic [VAL_W-1:0] PRIME_MOD = 30'd1000000007;
  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

  // register index, taken from paddr[2]
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DIFF,
    ST_WALK,
    ST_QREAD,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic clear_step;
    logic decode;
    logic set_entry;
    logic start_walk;
    logic rd_query;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic idx_bad;
    logic diff_zero;
    logic walk_done;
    logic clear_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME_MOD}) begin
      return VAL_W'(s - {1'b0, PRIME_MOD});
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/bpsmp_ctrl.sv =====
`default_nettype none

module bpsmp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tvalid_i,
  output logic                  tready_o,
  input  bpsmp_pkg::dp_status_t status_i,
  output bpsmp_pkg::dp_cmd_t    cmd_o
);
  import bpsmp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        tready_o      = 1'b1;
        cmd_o.capture = tvalid_i;
        if (tvalid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (status_i.is_query) begin
          state_d = status_i.idx_bad ? ST_RESULT : ST_QREAD;
        end else begin
          state_d = status_i.idx_bad ? ST_IDLE : ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.set_entry = 1'b1;
        if (status_i.diff_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.start_walk = 1'b1;
          state_d          = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.walk_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_QREAD: begin
        cmd_o.rd_query = 1'b1;
        state_d        = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/bpsmp_dp.sv =====
`default_nettype none
`include "blocked_prefix_sum_mod_prime_macros.svh"

module bpsmp_dp #(
  parameter int unsigned MAX_ELEMENTS = bpsmp_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned BLOCK_SIZE   = bpsmp_pkg::BLOCK_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpsmp_pkg::dp_cmd_t          cmd_i,
  output bpsmp_pkg::dp_status_t       status_o,
  input  logic [bpsmp_pkg::CNT_W-1:0] element_count_i,
  input  logic                        in_opcode_i,
  input  logic [bpsmp_pkg::IDX_W-1:0] in_index_i,
  input  logic [bpsmp_pkg::VAL_W-1:0] in_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bpsmp_pkg::VAL_W-1:0] out_prefix_sum_o,
  output logic                        out_index_error_o
);
  import bpsmp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned NB = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned RECIP_SHIFT = AW + $clog2(BLOCK_SIZE);
  localparam int unsigned MUL_W = AW + 2;
  localparam int unsigned PROD_W = AW + MUL_W;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE);

  // storage
  logic [VAL_W-1:0] ev_mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] pf_mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] of_mem [NB];

  // captured item
  logic             op_q;
  logic             idx_zero_q;
  logic             idx_err_q;
  logic [AW-1:0]    pos_q;
  logic [VAL_W-1:0] val_q;
  logic [BW-1:0]    blk_q;
  logic [AW:0]      end_q;
  logic [VAL_W-1:0] diff_q;

  // walkers
  logic [AW:0]      ip_q;
  logic             ip_act_q;
  logic [AW-1:0]    ip_wa_q;
  logic             ip_pend_q;
  logic [BW:0]      jp_q;
  logic             jp_act_q;
  logic [BW-1:0]    jp_wa_q;
  logic             jp_pend_q;

  logic [AW-1:0]    clr_q;

  logic [VAL_W-1:0] ev_rdata_q;
  logic [VAL_W-1:0] pf_rdata_q;
  logic [VAL_W-1:0] of_rdata_q;

  logic             out_valid_q;
  logic [VAL_W-1:0] out_sum_q;
  logic             out_err_q;

  // comb
  logic [IDX_W-1:0] idx_m1;
  logic             idx_err_d;
  logic [VAL_W-1:0] val_red;
  logic [PROD_W-1:0] blk_prod;
  logic [BW-1:0]    blk_d;
  logic [31:0]      blk_end_raw;
  logic [AW:0]      end_d;
  logic [VAL_W:0]   diff_wrap;
  logic [VAL_W-1:0] diff_d;
  logic [AW:0]      ip_nxt;
  logic [BW:0]      jp_start;
  logic [BW:0]      jp_nxt;
  logic             clr_in_nb;

  logic             ev_we;
  logic [AW-1:0]    ev_wa;
  logic [VAL_W-1:0] ev_wd;
  logic             pf_we;
  logic [AW-1:0]    pf_wa;
  logic [VAL_W-1:0] pf_wd;
  logic             pf_re;
  logic [AW-1:0]    pf_ra;
  logic             of_we;
  logic [BW-1:0]    of_wa;
  logic [VAL_W-1:0] of_wd;
  logic             of_re;
  logic [BW-1:0]    of_ra;

  assign idx_m1    = in_index_i - IDX_W'(1);
  assign idx_err_d = (in_index_i > element_count_i) ||
                     (32'(in_index_i) > 32'(MAX_ELEMENTS));
  assign val_red   = (in_value_i >= PRIME_MOD) ? in_value_i - PRIME_MOD : in_value_i;

  // block number by reciprocal multiply, exact over the address range
  assign blk_prod = PROD_W'(pos_q) * PROD_W'(RECIP_MUL);
  assign blk_d    = blk_prod[RECIP_SHIFT +: BW];

  assign blk_end_raw = (32'(blk_q) + 32'd1) * 32'(BLOCK_SIZE);
  assign end_d = (blk_end_raw > 32'(MAX_ELEMENTS)) ? (AW+1)'(MAX_ELEMENTS)
                                                   : (AW+1)'(blk_end_raw);

  assign diff_wrap = {1'b0, val_q} + {1'b0, PRIME_MOD} - {1'b0, ev_rdata_q};
  assign diff_d    = (val_q >= ev_rdata_q) ? val_q - ev_rdata_q : diff_wrap[VAL_W-1:0];

  assign ip_nxt   = ip_q + (AW+1)'(1);
  assign jp_start = {1'b0, blk_q} + (BW+1)'(1);
  assign jp_nxt   = jp_q + (BW+1)'(1);

  assign clr_in_nb = 32'(clr_q) < 32'(NB);

  // memory port selection
  assign ev_we = cmd_i.clear_step | cmd_i.set_entry;
  assign ev_wa = cmd_i.clear_step ? clr_q : pos_q;
  assign ev_wd = cmd_i.clear_step ? '0 : val_q;

  assign pf_we = cmd_i.clear_step | ip_pend_q;
  assign pf_wa = cmd_i.clear_step ? clr_q : ip_wa_q;
  assign pf_wd = cmd_i.clear_step ? '0 : add_mod(pf_rdata_q, diff_q);
  assign pf_re = ip_act_q | cmd_i.rd_query;
  assign pf_ra = ip_act_q ? ip_q[AW-1:0] : pos_q;

  assign of_we = (cmd_i.clear_step & clr_in_nb) | jp_pend_q;
  assign of_wa = cmd_i.clear_step ? clr_q[BW-1:0] : jp_wa_q;
  assign of_wd = cmd_i.clear_step ? '0 : add_mod(of_rdata_q, diff_q);
  assign of_re = jp_act_q | cmd_i.rd_query;
  assign of_ra = jp_act_q ? jp_q[BW-1:0] : blk_q;

  always_ff @(posedge clk_i) begin
    if (ev_we) begin
      ev_mem[ev_wa] <= ev_wd;
    end
    if (cmd_i.decode) begin
      ev_rdata_q <= ev_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pf_we) begin
      pf_mem[pf_wa] <= pf_wd;
    end
    if (pf_re) begin
      pf_rdata_q <= pf_mem[pf_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (of_we) begin
      of_mem[of_wa] <= of_wd;
    end
    if (of_re) begin
      of_rdata_q <= of_mem[of_ra];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_opcode_i;
      idx_zero_q <= (in_index_i == '0);
      idx_err_q  <= idx_err_d;
      pos_q      <= AW'(idx_m1);
      val_q      <= val_red;
    end
    if (cmd_i.decode) begin
      blk_q <= blk_d;
    end
    if (cmd_i.set_entry) begin
      end_q  <= end_d;
      diff_q <= diff_d;
    end
    if (cmd_i.start_walk) begin
      ip_q <= {1'b0, pos_q};
      jp_q <= jp_start;
    end else begin
      if (ip_act_q) begin
        ip_q <= ip_nxt;
      end
      if (jp_act_q) begin
        jp_q <= jp_nxt;
      end
    end
    ip_wa_q <= ip_q[AW-1:0];
    jp_wa_q <= jp_q[BW-1:0];
    if (cmd_i.load_result) begin
      out_sum_q <= (idx_err_q | idx_zero_q) ? '0 : add_mod(pf_rdata_q, of_rdata_q);
      out_err_q <= idx_err_q;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_act_q    <= 1'b0;
      ip_pend_q   <= 1'b0;
      jp_act_q    <= 1'b0;
      jp_pend_q   <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ip_pend_q <= ip_act_q;
      jp_pend_q <= jp_act_q;
      if (cmd_i.start_walk) begin
        ip_act_q <= 1'b1;
        jp_act_q <= 32'(jp_start) < 32'(NB);
      end else begin
        if (ip_act_q && (ip_nxt == end_q)) begin
          ip_act_q <= 1'b0;
        end
        if (jp_act_q && (32'(jp_nxt) >= 32'(NB))) begin
          jp_act_q <= 1'b0;
        end
      end
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.is_query   = op_q;
  assign status_o.idx_bad    = idx_err_q | idx_zero_q;
  assign status_o.diff_zero  = (diff_d == '0);
  assign status_o.walk_done  = ~(ip_act_q | ip_pend_q | jp_act_q | jp_pend_q);
  assign status_o.clear_last = (clr_q == AW'(MAX_ELEMENTS - 1));
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_prefix_sum_o  = out_sum_q;
  assign out_index_error_o = out_err_q;

  `BPSMP_ASSERT_IMP(a_walk_in_block, ip_pend_q, (AW+1)'(ip_wa_q) < end_q,
                    "in-block walk wrote past the end of its block")
  `BPSMP_ASSERT_IMP(a_walk_lead, ip_pend_q && ip_act_q, ip_q[AW-1:0] == ip_wa_q + AW'(1),
                    "in-block read does not lead its write by one entry")
  `BPSMP_ASSERT_IMP(a_offset_later, jp_pend_q, jp_wa_q > blk_q,
                    "offset walk touched a block that is not later")
  `BPSMP_ASSERT_IMP(a_no_result_in_clear, cmd_i.clear_step, !out_valid_q,
                    "result pending during clearing pass")
  `BPSMP_ASSERT_NXT(a_walk_holds_input, ip_act_q || jp_act_q, !cmd_i.capture,
                    "new word taken while an update walk is still running")

endmodule

`default_nettype wire

// ===== src/blocked_prefix_sum_mod_prime.sv =====
`default_nettype none

// Prefix sums modulo 1000000007 over an array of MAX_ELEMENTS residues kept in
// blocks of BLOCK_SIZE entries, each entry holding its in-block prefix and each
// block an offset. Input word: tuser = opcode (0 set, 1 query), tdata = index
// then value. Index counts from 1; a query at index 0 returns 0, an index above
// element_count (or MAX_ELEMENTS) returns 0 with index_error set, and such a
// set is dropped. Only queries produce an output word. A query passes through
// decode, a read of entry prefix and block offset, and a result state (index 0
// or out of range go straight from decode to the result state); the result is
// loaded once the output register is free, and the next word is taken in idle.
// A set ends after its difference step when the value is unchanged; otherwise
// one walker steps through the rest of the entry's block while a second steps
// through the later block offsets, each a read-modify-write on its own memory
// at one entry per cycle. After reset a clearing pass zeroes the memories and
// no input word is taken until it ends; register writes are taken at any time.
module blocked_prefix_sum_mod_prime #(
  parameter int unsigned MAX_ELEMENTS = bpsmp_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned BLOCK_SIZE   = bpsmp_pkg::BLOCK_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpsmp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bpsmp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bpsmp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bpsmp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // index[12:0], value[42:13]
  input  logic [0:0]                        s_axis_tuser,  // opcode[0]
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bpsmp_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // prefix_sum[29:0]
  output logic [0:0]                        m_axis_tuser   // index_error[0]
);
  import bpsmp_pkg::*;

  logic [CNT_W-1:0] element_count_q;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [VAL_W-1:0] prefix_sum;
  logic             index_error;

  assign reg_sel = (paddr[2] == REG_ELEMENT_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(element_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      element_count_q <= pwdata[CNT_W-1:0];
    end
  end

  bpsmp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  bpsmp_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .BLOCK_SIZE   (BLOCK_SIZE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .element_count_i   (element_count_q),
    .in_opcode_i       (s_axis_tuser[0]),
    .in_index_i        (s_axis_tdata[IDX_W-1:0]),
    .in_value_i        (s_axis_tdata[IDX_W +: VAL_W]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_prefix_sum_o  (prefix_sum),
    .out_index_error_o (index_error)
  );

  assign m_axis_tdata    = M_TDATA_W'(prefix_sum);
  assign m_axis_tuser[0] = index_error;

endmodule

`default_nettype wire
